// ===== src/ydvr_pkg.sv =====
// ============================================================================
// ydvr_pkg: shared types and constants for the yaw delta vector rotator
// Angle units, datapath widths, quadrant codes and the arctangent table of
// the pipelined CORDIC rotator.
// ============================================================================
package ydvr_pkg;

    // Field widths
    localparam int YAW_W   = 17;
    localparam int PITCH_W = 16;
    localparam int MOV_W   = 16;

    // Internal datapath widths
    localparam int DIFF_W  = 19;   // yaw difference with headroom for a full-turn add
    localparam int DELTA_W = 16;   // reduced delta, 0..46079
    localparam int RES_W   = 14;   // residual angle, -5760..5759
    localparam int ROT_W   = 17;   // movement after quarter turn (holds +32768)
    localparam int GAIN_W  = 25;
    localparam int XY_W    = 42;   // Q24 vector components
    localparam int Z_W     = 28;   // angle accumulator, 2^-20 degree
    localparam int Z_SHIFT = 13;   // 1/128 degree to 2^-20 degree
    localparam int FRAC_W  = 24;   // fraction bits of x and y
    localparam int OUT_W   = XY_W - FRAC_W;

    // Angle constants in 1/128 degree
    localparam int ANGLE_FULL    = 46080;
    localparam int ANGLE_QUARTER = 11520;
    localparam int ANGLE_EIGHTH  = 5760;
    localparam int PITCH_LIMIT   = 11520;

    localparam int ATAN_ENTRIES = 24;

    // CORDIC gain compensation in Q24
    localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;

    // Coarse quarter-turn applied ahead of the CORDIC
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } ydvr_quad_t;

    // Vector state carried through the rotator stages
    typedef struct packed {
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
        logic            neg;
    } ydvr_vec_t;

    // atan(2^-i) in degrees scaled by 2^20, rounded to nearest
    function automatic logic [Z_W-1:0] atan_value(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 28'd47185920;
            5'd1:    v = 28'd27855475;
            5'd2:    v = 28'd14718068;
            5'd3:    v = 28'd7471121;
            5'd4:    v = 28'd3750058;
            5'd5:    v = 28'd1876857;
            5'd6:    v = 28'd938658;
            5'd7:    v = 28'd469357;
            5'd8:    v = 28'd234682;
            5'd9:    v = 28'd117342;
            5'd10:   v = 28'd58671;
            5'd11:   v = 28'd29335;
            5'd12:   v = 28'd14668;
            5'd13:   v = 28'd7334;
            5'd14:   v = 28'd3667;
            5'd15:   v = 28'd1833;
            5'd16:   v = 28'd917;
            5'd17:   v = 28'd458;
            5'd18:   v = 28'd229;
            5'd19:   v = 28'd115;
            5'd20:   v = 28'd57;
            5'd21:   v = 28'd29;
            5'd22:   v = 28'd14;
            5'd23:   v = 28'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/yaw_delta_vector_rotator.sv =====
// ============================================================================
// yaw_delta_vector_rotator: rotate a movement pair by a yaw change
// Reduces the yaw delta mod 360 degrees, applies a quarter turn and a
// pipelined CORDIC, then rounds, flips forward on steep pitch and saturates.
// ============================================================================
// The block accepts one beat per clock unless back-pressure stalls it, and returns one
// result beat per input beat, in order. The path holds three front stages (delta
// reduction, quarter turn, gain multiply), one register per CORDIC micro-rotation,
// and the output register that rounds and saturates.
// Every stage has its own valid bit and passes ready back, so an empty stage
// keeps taking beats while the output register holds a result.
module yaw_delta_vector_rotator #(
    parameter int ROTATION_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // old_yaw[16:0], new_yaw[33:17], new_pitch[49:34], old_forward[65:50],
    // old_side[81:66], zero[87:82]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_forward[15:0], new_side[31:16]
    output logic [31:0] m_axis_tdata
);
    import ydvr_pkg::*;

    localparam int NSTEPS = (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS : ATAN_ENTRIES;

    // Input fields
    logic signed [YAW_W-1:0]   old_yaw;
    logic signed [YAW_W-1:0]   new_yaw;
    logic signed [PITCH_W-1:0] new_pitch;
    logic signed [MOV_W-1:0]   old_forward;
    logic signed [MOV_W-1:0]   old_side;

    assign old_yaw     = s_axis_tdata[16:0];
    assign new_yaw     = s_axis_tdata[33:17];
    assign new_pitch   = s_axis_tdata[49:34];
    assign old_forward = s_axis_tdata[65:50];
    assign old_side    = s_axis_tdata[81:66];

    // Front stage valid bits and ready chain
    logic [2:0] pre_vld_reg;
    logic [2:0] pre_rdy;

    // CORDIC chain
    ydvr_vec_t         cvec [NSTEPS+1];
    logic [NSTEPS:0]   cvld;
    logic [NSTEPS:0]   crdy;

    // Stage 0: reduced delta
    logic signed [DIFF_W-1:0]  diff;
    logic [DELTA_W-1:0]        d_next;
    logic [DELTA_W-1:0]        d_reg;
    logic signed [MOV_W-1:0]   f0_reg;
    logic signed [MOV_W-1:0]   s0_reg;
    logic                      neg0_reg;
    logic                      neg0_next;

    // Stage 1: quarter turn and residual
    logic signed [DIFF_W-1:0]  dd;
    logic signed [DIFF_W-1:0]  r_wide;
    ydvr_quad_t                quad;
    logic signed [ROT_W-1:0]   fe;
    logic signed [ROT_W-1:0]   se;
    logic signed [ROT_W-1:0]   f1_next;
    logic signed [ROT_W-1:0]   s1_next;
    logic signed [ROT_W-1:0]   f1_reg;
    logic signed [ROT_W-1:0]   s1_reg;
    logic signed [RES_W-1:0]   r1_reg;
    logic                      neg1_reg;

    // Stage 2: gain compensation
    ydvr_vec_t                 g_next;
    ydvr_vec_t                 g_reg;

    // Output stage
    logic                      out_vld_reg;
    logic                      out_rdy;
    logic signed [XY_W-1:0]    xr;
    logic signed [XY_W-1:0]    yr;
    logic signed [OUT_W:0]     fo;
    logic signed [OUT_W:0]     so;
    logic [MOV_W-1:0]          fwd_next;
    logic [MOV_W-1:0]          side_next;
    logic [MOV_W-1:0]          fwd_reg;
    logic [MOV_W-1:0]          side_reg;

    // Ready pass-back through the front stages
    assign out_rdy    = ~out_vld_reg | m_axis_tready;
    assign pre_rdy[2] = ~pre_vld_reg[2] | crdy[0];
    assign pre_rdy[1] = ~pre_vld_reg[1] | pre_rdy[2];
    assign pre_rdy[0] = ~pre_vld_reg[0] | pre_rdy[1];
    assign s_axis_tready = pre_rdy[0];

    // Advance the front valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= '0;
        else
        begin
            if (pre_rdy[0])
                pre_vld_reg[0] <= s_axis_tvalid;
            if (pre_rdy[1])
                pre_vld_reg[1] <= pre_vld_reg[0];
            if (pre_rdy[2])
                pre_vld_reg[2] <= pre_vld_reg[1];
        end
    end

    // Reduce new minus old yaw into one turn (the difference reaches almost three turns either way)
    always_comb
    begin
        diff = DIFF_W'(new_yaw) - DIFF_W'(old_yaw);
        if (diff < -2 * ANGLE_FULL)
            d_next = DELTA_W'(diff + DIFF_W'(3 * ANGLE_FULL));
        else if (diff < -ANGLE_FULL)
            d_next = DELTA_W'(diff + DIFF_W'(2 * ANGLE_FULL));
        else if (diff < 0)
            d_next = DELTA_W'(diff + DIFF_W'(ANGLE_FULL));
        else if (diff >= 2 * ANGLE_FULL)
            d_next = DELTA_W'(diff - DIFF_W'(2 * ANGLE_FULL));
        else if (diff >= ANGLE_FULL)
            d_next = DELTA_W'(diff - DIFF_W'(ANGLE_FULL));
        else
            d_next = DELTA_W'(diff);
        neg0_next = (new_pitch < -PITCH_LIMIT) || (new_pitch > PITCH_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (pre_rdy[0] && s_axis_tvalid)
        begin
            d_reg    <= d_next;
            f0_reg   <= old_forward;
            s0_reg   <= old_side;
            neg0_reg <= neg0_next;
        end
    end

    // Pick the nearest quarter turn and apply it exactly
    always_comb
    begin
        dd = DIFF_W'({1'b0, d_reg});
        if (dd < ANGLE_EIGHTH)
        begin
            quad   = QUAD_0;
            r_wide = dd;
        end
        else if (dd < ANGLE_QUARTER + ANGLE_EIGHTH)
        begin
            quad   = QUAD_90;
            r_wide = dd - DIFF_W'(ANGLE_QUARTER);
        end
        else if (dd < 2 * ANGLE_QUARTER + ANGLE_EIGHTH)
        begin
            quad   = QUAD_180;
            r_wide = dd - DIFF_W'(2 * ANGLE_QUARTER);
        end
        else if (dd < 3 * ANGLE_QUARTER + ANGLE_EIGHTH)
        begin
            quad   = QUAD_270;
            r_wide = dd - DIFF_W'(3 * ANGLE_QUARTER);
        end
        else
        begin
            quad   = QUAD_0;
            r_wide = dd - DIFF_W'(ANGLE_FULL);
        end

        fe = ROT_W'(f0_reg);
        se = ROT_W'(s0_reg);
        case (quad)
            QUAD_90:
            begin
                f1_next = -se;
                s1_next = fe;
            end
            QUAD_180:
            begin
                f1_next = -fe;
                s1_next = -se;
            end
            QUAD_270:
            begin
                f1_next = se;
                s1_next = -fe;
            end
            default:
            begin
                f1_next = fe;
                s1_next = se;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pre_rdy[1] && pre_vld_reg[0])
        begin
            f1_reg   <= f1_next;
            s1_reg   <= s1_next;
            r1_reg   <= RES_W'(r_wide);
            neg1_reg <= neg0_reg;
        end
    end

    // Scale by the CORDIC gain and convert the residual angle
    always_comb
    begin
        g_next.x   = XY_W'(f1_reg * GAIN_Q24);
        g_next.y   = XY_W'(s1_reg * GAIN_Q24);
        g_next.z   = Z_W'(r1_reg) <<< Z_SHIFT;
        g_next.neg = neg1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pre_rdy[2] && pre_vld_reg[1])
            g_reg <= g_next;
    end

    assign cvec[0] = g_reg;
    assign cvld[0] = pre_vld_reg[2];
    assign crdy[NSTEPS] = out_rdy;

    // Micro-rotation pipeline
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cordic
        ydvr_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (cvld[i]),
            .in_data    (cvec[i]),
            .down_ready (crdy[i+1]),
            .up_ready   (crdy[i]),
            .out_valid  (cvld[i+1]),
            .out_data   (cvec[i+1])
        );
    end

    // Round, flip forward on steep pitch, saturate
    always_comb
    begin
        xr = $signed(cvec[NSTEPS].x) + XY_W'(64'sd1 <<< (FRAC_W - 1));
        yr = $signed(cvec[NSTEPS].y) + XY_W'(64'sd1 <<< (FRAC_W - 1));
        fo = (OUT_W+1)'($signed(xr[XY_W-1:FRAC_W]));
        so = (OUT_W+1)'($signed(yr[XY_W-1:FRAC_W]));
        if (cvec[NSTEPS].neg)
            fo = -fo;
        if (fo > 32767)
            fwd_next = 16'h7FFF;
        else if (fo < -32768)
            fwd_next = 16'h8000;
        else
            fwd_next = MOV_W'(fo);
        if (so > 32767)
            side_next = 16'h7FFF;
        else if (so < -32768)
            side_next = 16'h8000;
        else
            side_next = MOV_W'(so);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_rdy)
            out_vld_reg <= cvld[NSTEPS];
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && cvld[NSTEPS])
        begin
            fwd_reg  <= fwd_next;
            side_reg <= side_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {side_reg, fwd_reg};

    // An empty output register frees the whole pipe back to the input
    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A finished rotation moves into an empty output register
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cvld[NSTEPS] && !out_vld_reg) |=> out_vld_reg)
        else $error("last rotation stage did not drain into output");

    // A blocked quarter-turn stage keeps its beat
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pre_vld_reg[1] && !pre_rdy[2]) |=>
            (pre_vld_reg[1] && $stable(f1_reg) && $stable(r1_reg)))
        else $error("stalled quarter-turn stage lost its beat");

endmodule

// ===== src/ydvr_cordic_stage.sv =====
// ============================================================================
// ydvr_cordic_stage: one registered CORDIC micro-rotation
// Rotates the vector by +/- atan(2^-STEP) depending on the sign of the
// residual angle, with its own valid bit and ready pass-back.
// ============================================================================
module ydvr_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ydvr_pkg::ydvr_vec_t in_data,
    input  logic                down_ready,
    output logic                up_ready,
    output logic                out_valid,
    output ydvr_pkg::ydvr_vec_t out_data
);
    import ydvr_pkg::*;

    logic                   valid_reg;
    ydvr_vec_t              data_reg;
    ydvr_vec_t              data_next;
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  angle;

    // Accept when empty or when the next stage takes the held beat
    assign up_ready = ~valid_reg | down_ready;

    // Micro-rotation toward zero residual angle
    always_comb
    begin
        x_in  = $signed(in_data.x);
        y_in  = $signed(in_data.y);
        z_in  = $signed(in_data.z);
        dx    = y_in >>> STEP;
        dy    = x_in >>> STEP;
        angle = $signed(atan_value(5'(STEP)));
        data_next.neg = in_data.neg;
        if (!z_in[Z_W-1])
        begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = z_in - angle;
        end
        else
        begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = z_in + angle;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= in_valid;
    end

    // Capture the rotated vector
    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== bench/yaw_delta_vector_rotator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// yaw_delta_vector_rotator_tb: self-checking bench for the yaw delta rotator
// Streams yaw/pitch/movement beats into the rotator in random bursts, stalls
// the result side on a shifting pattern, and compares every result beat with
// an in-bench fixed-point CORDIC predictor, field by field and in order.
// ============================================================================
module yaw_delta_vector_rotator_tb;

    localparam int STEPS        = 16;
    localparam int LATENCY      = ((STEPS < 24) ? STEPS : 24) + 4;
    localparam int RANDOM_ITEMS = 1100;

    // Angle units are 1/128 degree
    localparam longint TURN      = 46080;
    localparam longint QUARTER   = 11520;
    localparam longint EIGHTH    = 5760;
    localparam longint STEEP     = 11520;
    localparam longint GAIN      = 10188014;
    localparam longint MOV_MAX   = 32767;
    localparam longint MOV_MIN   = -32768;

    // atan(2^-i) in degrees, scaled by 2^20
    localparam longint ARCTAN [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic              drain_first;   // hold this beat until all results are back
        logic signed [16:0] old_yaw;
        logic signed [16:0] new_yaw;
        logic signed [15:0] new_pitch;
        logic signed [15:0] old_forward;
        logic signed [15:0] old_side;
    } heading_beat_t;

    typedef struct packed {
        logic signed [15:0] new_forward;
        logic signed [15:0] new_side;
    } movement_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // old_yaw[16:0], new_yaw[33:17], new_pitch[49:34], old_forward[65:50],
    // old_side[81:66], zero[87:82]
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // new_forward[15:0], new_side[31:16]
    logic [31:0] m_axis_tdata;

    heading_beat_t beat_queue[$];
    movement_t     movement_queue[$];
    heading_beat_t held_beat;
    movement_t     seen_movement;
    movement_t     want_movement;

    int  mismatches = 0;
    int  beats_sent = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic send_next;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  rx_mode = 0;
    int  rx_phase_left = 0;
    logic ready_next;

    yaw_delta_vector_rotator #(
        .ROTATION_STEPS(STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_movement(input longint v);
        if (v > MOV_MAX)
            return MOV_MAX;
        if (v < MOV_MIN)
            return MOV_MIN;
        return v;
    endfunction

    // Rotate the movement pair by the wrapped yaw delta
    function automatic movement_t rotate_movement(input heading_beat_t b);
        longint    delta, quad, resid, fwd, side, tmp, x, y, z, dx, dy, pitch, fo, so;
        movement_t res;
        delta = ($signed(b.new_yaw) - $signed(b.old_yaw)) % TURN;
        if (delta < 0)
            delta += TURN;
        quad  = (delta + EIGHTH) / QUARTER;
        resid = delta - quad * QUARTER;
        fwd   = $signed(b.old_forward);
        side  = $signed(b.old_side);
        pitch = $signed(b.new_pitch);
        // coarse quarter turn
        case (quad % 4)
            1:
            begin
                tmp = fwd; fwd = -side; side = tmp;
            end
            2:
            begin
                fwd = -fwd; side = -side;
            end
            3:
            begin
                tmp = fwd; fwd = side; side = -tmp;
            end
            default: ;
        endcase
        x = fwd * GAIN;
        y = side * GAIN;
        z = resid * 8192;
        // micro-rotations toward zero residual angle
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        fo = (x + (longint'(1) << 23)) >>> 24;
        so = (y + (longint'(1) << 23)) >>> 24;
        if (pitch < -STEEP || pitch > STEEP)
            fo = -fo;
        res.new_forward = 16'(clamp_movement(fo));
        res.new_side    = 16'(clamp_movement(so));
        return res;
    endfunction

    function automatic heading_beat_t make_beat(input int oy, input int ny, input int pitch,
                                                input int fwd, input int side);
        heading_beat_t b;
        b.drain_first = 1'b0;
        b.old_yaw     = 17'(oy);
        b.new_yaw     = 17'(ny);
        b.new_pitch   = 16'(pitch);
        b.old_forward = 16'(fwd);
        b.old_side    = 16'(side);
        return b;
    endfunction

    function automatic int pick_movement();
        int edges [4];
        edges = '{-32768, 32767, 0, -1};
        if ($urandom_range(0, 9) == 0)
            return edges[$urandom_range(0, 3)];
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Mostly in-range angles, with some raw bit patterns for the wrap logic
    function automatic heading_beat_t random_beat();
        int oy, ny, pitch;
        if ($urandom_range(0, 4) == 0)
            oy = $urandom_range(0, 131071);
        else
            oy = int'($urandom_range(0, 92159)) - 46080;
        if ($urandom_range(0, 4) == 0)
            ny = $urandom_range(0, 131071);
        else
            ny = int'($urandom_range(0, 92159)) - 46080;
        case ($urandom_range(0, 9))
            0: pitch = $urandom_range(0, 65535);
            1: pitch = int'($urandom_range(0, 2)) - 1 +
                       (($urandom_range(0, 1) != 0) ? 11520 : -11520);
            default: pitch = int'($urandom_range(0, 46080)) - 23040;
        endcase
        return make_beat(oy, ny, pitch, pick_movement(), pick_movement());
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, want %0d (result %0d)",
                 what, got, want, beats_sent);
        mismatches++;
    endtask

    // Driver: present queued beats in bursts, record the prediction on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            send_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                movement_queue.push_back(rotate_movement(held_beat));
                beats_sent++;
                send_next = 1'b0;
            end
            if (!send_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (beat_queue.size() > 0 &&
                         !(beat_queue[0].drain_first && movement_queue.size() > 0))
                begin
                    held_beat = beat_queue.pop_front();
                    s_axis_tdata <= {6'b0, held_beat.old_side, held_beat.old_forward,
                                     held_beat.new_pitch, held_beat.new_yaw, held_beat.old_yaw};
                    send_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid <= send_next;
        end
    end

    // Receiver: one long hold-off, otherwise stall on a shifting pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!long_hold_done && beats_sent >= 400)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
                ready_next = 1'b0;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(16, 96);
                end
                rx_phase_left--;
                case (rx_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) != 0);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ($urandom_range(0, 9) != 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_movement.new_forward = m_axis_tdata[15:0];
            seen_movement.new_side    = m_axis_tdata[31:16];
            if (movement_queue.size() == 0)
                report_mismatch("unexpected beat new_forward", seen_movement.new_forward, 0);
            else
            begin
                want_movement = movement_queue.pop_front();
                if (seen_movement.new_forward !== want_movement.new_forward)
                    report_mismatch("new_forward", seen_movement.new_forward,
                                    want_movement.new_forward);
                if (seen_movement.new_side !== want_movement.new_side)
                    report_mismatch("new_side", seen_movement.new_side,
                                    want_movement.new_side);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        heading_beat_t b;
        // zero, full-scale movement and no rotation
        beat_queue.push_back(make_beat(0, 0, 0, 0, 0));
        beat_queue.push_back(make_beat(0, 0, 0, 32767, 0));
        beat_queue.push_back(make_beat(0, 0, 0, -32768, -32768));
        // steep pitch and its boundaries: negate, and saturate when negating the most negative value
        beat_queue.push_back(make_beat(0, 0, 11521, -32768, 0));
        beat_queue.push_back(make_beat(0, 0, 11520, 1000, -500));
        beat_queue.push_back(make_beat(0, 0, -11520, 1000, -500));
        beat_queue.push_back(make_beat(0, 0, -11521, 1000, -500));
        beat_queue.push_back(make_beat(0, 0, 23040, 32767, 32767));
        beat_queue.push_back(make_beat(0, 0, -23040, -32768, 12345));
        beat_queue.push_back(make_beat(0, 0, -32768, 4000, 4000));
        beat_queue.push_back(make_beat(0, 0, 32767, 4000, -4000));
        // quarter turns and the boundaries between them
        beat_queue.push_back(make_beat(0, 11520, 0, 32767, -32768));
        beat_queue.push_back(make_beat(0, 23040, 0, -32768, 32767));
        beat_queue.push_back(make_beat(0, 34560, 0, 32767, -32768));
        beat_queue.push_back(make_beat(0, 5760, 0, 32767, 32767));
        beat_queue.push_back(make_beat(0, 5759, 0, 32767, 32767));
        beat_queue.push_back(make_beat(0, -5760, 0, 32767, -32768));
        beat_queue.push_back(make_beat(0, -1, 0, 20000, 20000));
        // yaw extremes and yaws beyond a full turn
        beat_queue.push_back(make_beat(-46080, 46079, 0, 16000, -16000));
        beat_queue.push_back(make_beat(46079, -46080, 0, 16000, -16000));
        beat_queue.push_back(make_beat(-65536, 65535, 0, -1234, 5678));
        beat_queue.push_back(make_beat(65535, -65536, -23040, 5678, -1234));
        beat_queue.push_back(make_beat(92160 - 131072, 100, 0, 30000, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            b = random_beat();
            // wait for the pipeline to empty before the random part and once midway
            if (n == 0 || n == 700)
                b.drain_first = 1'b1;
            beat_queue.push_back(b);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_queue.size() > 0 || s_axis_tvalid || movement_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && movement_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ydvr_pkg.sv
src/ydvr_cordic_stage.sv
src/yaw_delta_vector_rotator.sv
bench/yaw_delta_vector_rotator_tb.sv
